// ===== hw/rtl/afsk_pkg.sv =====
// ----------------------------------------------------------------------------
// AFSK demodulator package
// Sequencer states and the elaboration-time builder for the cosine/sine table.
// ----------------------------------------------------------------------------
`default_nettype none

package afsk_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX,
        ST_FILT,
        ST_IQUPD,
        ST_SQ,
        ST_SQACC,
        ST_PLO,
        ST_PHI,
        ST_PUPD,
        ST_HLO,
        ST_HHI,
        ST_HCMP,
        ST_RINIT,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        CFG_MARK_STEP  = 2'd0,
        CFG_SPACE_STEP = 2'd1,
        CFG_ALPHA      = 2'd2,
        CFG_HYST       = 2'd3
    } t_cfg_index;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
    localparam logic [11:0] SAMPLE_MID  = 12'd2048;

    // Sine of k/(4*2^lg) turns in Q1.15, from a Taylor series in Q30.
    function automatic logic [15:0] trig_sine(input logic [12:0] k_in, input int lg);
        logic [63:0] n;
        logic [63:0] k;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] v;
        n = 64'd1 << lg;
        k = {51'd0, k_in} & ((n << 2) - 64'd1);
        q = k >> lg;
        r = k & (n - 64'd1);
        if (q[0]) begin
            r = n - r;
        end
        x = (r * PI_HALF_Q30 + (n >> 1)) >> lg;
        t = x;
        sum = x;
        for (int j = 1; j <= 7; j++) begin
            t = (t * x) >> 30;
            t = (t * x) >> 30;
            case (j)
                1:       t = t / 6;
                2:       t = t / 20;
                3:       t = t / 42;
                4:       t = t / 72;
                5:       t = t / 110;
                6:       t = t / 156;
                default: t = t / 210;
            endcase
            if (j % 2 == 1) begin
                sum = sum - t;
            end else begin
                sum = sum + t;
            end
        end
        v = (sum + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        if (q[1]) begin
            v = -v;
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/afsk_quadrature_demodulator_core.sv =====
// ----------------------------------------------------------------------------
// AFSK quadrature demodulator core
// Mixes each sample with mark and space oscillators, filters I/Q and power,
// decides the tone with hysteresis and slices NRZI bits into bytes.
// ----------------------------------------------------------------------------
// One word at a time: a sample is taken only in the idle state, and a
// result that is still waiting holds the sequencer in its last state. All
// products go through one shared 25x25 signed multiplier, and the ratio uses
// a 7-step restoring divider.
// Reset (synchronous, active low) clears filters, phases and tone state and
// loads the default register values. The table is constant logic.
`default_nettype none

module afsk_quadrature_demodulator_core #(
    parameter int BIT_PERIOD    = 8,
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [11:0] adc_sample
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [0] tone_known, [1] tone_is_mark, [2] edge_seen, [3] bit_ready,
    // [4] bit_value, [5] byte_ready, [13:6] byte_value, [20:14] signal_ratio
    output logic [23:0]      o_m_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int TBL_LG = $clog2(TABLE_ENTRIES);
    localparam logic [6:0] BIT_MID = 7'(BIT_PERIOD / 2);
    localparam logic [6:0] BIT_LEN = 7'(BIT_PERIOD);

    // Constant cosine/sine table, cosine in the upper half.
    logic [31:0] w_rom [TABLE_ENTRIES];
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
        assign w_rom[g] = {
            afsk_pkg::trig_sine(13'(4 * g + TABLE_ENTRIES), TBL_LG),
            afsk_pkg::trig_sine(13'(4 * g), TBL_LG)
        };
    end

    afsk_pkg::t_state r_state, n_state;

    logic [15:0] r_mark_step, r_space_step, r_alpha, r_hyst;
    logic [15:0] r_mark_phase, r_space_phase;
    logic signed [12:0] r_sample;
    logic signed [23:0] r_iq [4];
    logic [47:0] r_acc [2];
    logic [47:0] r_pow [2];
    logic [1:0]  r_k;
    logic signed [49:0] r_prod;
    logic signed [49:0] r_lo;
    logic        r_mark_win, r_space_win;
    logic [54:0] r_rem;
    logic [48:0] r_den;
    logic [2:0]  r_cnt;
    logic [6:0]  r_quo;
    logic        r_known, r_mark, r_slice_known, r_slice_mark;
    logic [6:0]  r_bit_clock;
    logic [2:0]  r_bits;
    logic [7:0]  r_shift;
    logic [6:0]  r_ratio;
    logic        r_ovalid;
    logic [23:0] r_odata;

    // Shared multiplier operands.
    logic signed [24:0] w_ma, w_mb;
    logic signed [49:0] w_mprod;

    logic [31:0]        w_trig;
    logic signed [15:0] w_tval;
    logic signed [24:0] w_iq_diff;
    logic signed [48:0] w_pow_diff;
    logic [47:0]        w_hop;
    logic signed [65:0] w_pow_sum;
    logic [63:0]        w_wide;
    logic [54:0]        w_trial;
    logic               w_ge;
    logic [47:0]        w_mpow, w_spow;

    // Result and bit-slicer next values.
    logic        w_new_known, w_new_mark, w_edge;
    logic [6:0]  w_bc;
    logic        w_slice, w_bit;
    logic [7:0]  w_shift_new;
    logic        w_byte;
    logic [6:0]  w_ratio_new;
    logic        w_fire;

    assign w_mpow = r_pow[0];
    assign w_spow = r_pow[1];

    assign w_trig = r_k[1] ? w_rom[r_space_phase[15 -: TBL_LG]]
                           : w_rom[r_mark_phase[15 -: TBL_LG]];
    assign w_tval = r_k[0] ? signed'(w_trig[15:0]) : signed'(w_trig[31:16]);
    assign w_iq_diff = 25'(r_prod[28:4] - 25'(r_iq[r_k]));
    assign w_pow_diff = signed'({1'b0, r_acc[r_k[0]]}) - signed'({1'b0, r_pow[r_k[0]]});
    assign w_hop = r_k[0] ? w_mpow : w_spow;
    assign w_pow_sum = (66'(r_prod) <<< 24) + 66'(r_lo);
    assign w_wide = (64'(r_prod[39:0]) << 24) + 64'(r_lo[39:0]);
    assign w_trial = 55'(r_den) << r_cnt;
    assign w_ge = r_rem >= w_trial;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            afsk_pkg::ST_MIX: begin
                w_ma = 25'(r_sample);
                w_mb = 25'(w_tval);
            end
            afsk_pkg::ST_FILT: begin
                w_ma = signed'({9'd0, r_alpha});
                w_mb = w_iq_diff;
            end
            afsk_pkg::ST_SQ: begin
                w_ma = 25'(r_iq[r_k]);
                w_mb = 25'(r_iq[r_k]);
            end
            afsk_pkg::ST_PLO: begin
                w_ma = signed'({9'd0, r_alpha});
                w_mb = signed'({1'b0, w_pow_diff[23:0]});
            end
            afsk_pkg::ST_PHI: begin
                w_ma = signed'({9'd0, r_alpha});
                w_mb = w_pow_diff[48:24];
            end
            afsk_pkg::ST_HLO: begin
                w_ma = signed'({9'd0, r_hyst});
                w_mb = signed'({1'b0, w_hop[23:0]});
            end
            afsk_pkg::ST_HHI: begin
                w_ma = signed'({9'd0, r_hyst});
                w_mb = signed'({1'b0, w_hop[47:24]});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mprod = w_ma * w_mb;

    // Tone decision, bit clock and slicer for the finishing sample.
    always_comb begin
        w_new_known = r_known;
        w_new_mark  = r_mark;
        if (r_mark_win) begin
            w_new_known = 1'b1;
            w_new_mark  = 1'b1;
        end else if (r_space_win) begin
            w_new_known = 1'b1;
            w_new_mark  = 1'b0;
        end
        w_edge = r_known && (w_new_mark != r_mark);
        w_bc = (w_edge ? 7'd0 : r_bit_clock) + 7'd1;
        w_slice = (w_bc == BIT_MID);
        w_bit = !r_slice_known || (w_new_known && (w_new_mark == r_slice_mark));
        w_shift_new = r_shift | (8'(w_bit) << r_bits);
        w_byte = w_slice && (r_bits == 3'd7);
        w_ratio_new = (r_den != '0) ? r_quo : r_ratio;
    end

    assign w_fire = (r_state == afsk_pkg::ST_FIN) && (!r_ovalid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            afsk_pkg::ST_IDLE:  if (i_s_tvalid) n_state = afsk_pkg::ST_MIX;
            afsk_pkg::ST_MIX:   n_state = afsk_pkg::ST_FILT;
            afsk_pkg::ST_FILT:  n_state = afsk_pkg::ST_IQUPD;
            afsk_pkg::ST_IQUPD: n_state = (r_k == 2'd3) ? afsk_pkg::ST_SQ : afsk_pkg::ST_MIX;
            afsk_pkg::ST_SQ:    n_state = afsk_pkg::ST_SQACC;
            afsk_pkg::ST_SQACC: n_state = (r_k == 2'd3) ? afsk_pkg::ST_PLO : afsk_pkg::ST_SQ;
            afsk_pkg::ST_PLO:   n_state = afsk_pkg::ST_PHI;
            afsk_pkg::ST_PHI:   n_state = afsk_pkg::ST_PUPD;
            afsk_pkg::ST_PUPD:  n_state = r_k[0] ? afsk_pkg::ST_HLO : afsk_pkg::ST_PLO;
            afsk_pkg::ST_HLO:   n_state = afsk_pkg::ST_HHI;
            afsk_pkg::ST_HHI:   n_state = afsk_pkg::ST_HCMP;
            afsk_pkg::ST_HCMP:  n_state = r_k[0] ? afsk_pkg::ST_RINIT : afsk_pkg::ST_HLO;
            afsk_pkg::ST_RINIT: n_state = afsk_pkg::ST_DIV;
            afsk_pkg::ST_DIV:   n_state = (r_cnt == 3'd0) ? afsk_pkg::ST_FIN : afsk_pkg::ST_DIV;
            afsk_pkg::ST_FIN:   if (w_fire) n_state = afsk_pkg::ST_IDLE;
            default:            n_state = afsk_pkg::ST_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == afsk_pkg::ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= afsk_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_step  <= 16'd8192;
            r_space_step <= 16'd15019;
            r_alpha      <= 16'd16384;
            r_hyst       <= 16'd19661;
        end else if (i_cfg_we) begin
            case (afsk_pkg::t_cfg_index'(i_cfg_index))
                afsk_pkg::CFG_MARK_STEP:  r_mark_step  <= i_cfg_wdata;
                afsk_pkg::CFG_SPACE_STEP: r_space_step <= i_cfg_wdata;
                afsk_pkg::CFG_ALPHA:      r_alpha      <= i_cfg_wdata;
                afsk_pkg::CFG_HYST:       r_hyst       <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Datapath registers, sequenced by r_state.
    always_ff @(posedge i_clk) begin
        r_prod <= w_mprod;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_iq[i] <= '0;
            end
            r_pow[0] <= '0;
            r_pow[1] <= '0;
        end else begin
            case (r_state)
                afsk_pkg::ST_IDLE: begin
                    r_sample <= signed'({1'b0, i_s_tdata[11:0]} - {1'b0, afsk_pkg::SAMPLE_MID});
                    r_k <= 2'd0;
                end
                afsk_pkg::ST_IQUPD: begin
                    r_iq[r_k] <= r_iq[r_k] + r_prod[39:16];
                    r_k <= r_k + 2'd1;
                end
                afsk_pkg::ST_SQACC: begin
                    r_acc[r_k[1]] <= (r_k[0] ? r_acc[r_k[1]] : 48'd0) + r_prod[47:0];
                    r_k <= r_k + 2'd1;
                end
                afsk_pkg::ST_PHI: r_lo <= r_prod;
                afsk_pkg::ST_PUPD: begin
                    r_pow[r_k[0]] <= r_pow[r_k[0]] + w_pow_sum[63:16];
                    r_k <= r_k[0] ? 2'd0 : 2'd1;
                end
                afsk_pkg::ST_HHI: r_lo <= r_prod;
                afsk_pkg::ST_HCMP: begin
                    if (r_k[0]) begin
                        r_space_win <= {w_spow, 14'd0} > w_wide;
                    end else begin
                        r_mark_win <= {w_mpow, 14'd0} > w_wide;
                    end
                    r_k <= 2'd1;
                end
                afsk_pkg::ST_RINIT: begin
                    r_rem <= (55'(w_mpow) << 6) + (55'(w_mpow) << 5) + (55'(w_mpow) << 2);
                    r_den <= 49'(w_mpow) + 49'(w_spow);
                    r_cnt <= 3'd6;
                    r_quo <= '0;
                end
                afsk_pkg::ST_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - w_trial;
                    end
                    r_quo <= {r_quo[5:0], w_ge};
                    r_cnt <= r_cnt - 3'd1;
                end
                default: ;
            endcase
            if (w_fire) begin
                r_odata <= {3'd0, w_ratio_new, w_byte ? w_shift_new : 8'd0, w_byte,
                            w_slice & w_bit, w_slice, w_edge, w_new_known & w_new_mark,
                            w_new_known};
            end
        end
    end

    // Oscillator phases, tone and bit state, output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_phase  <= '0;
            r_space_phase <= '0;
            r_known       <= 1'b0;
            r_mark        <= 1'b0;
            r_slice_known <= 1'b0;
            r_slice_mark  <= 1'b0;
            r_bit_clock   <= '0;
            r_bits        <= '0;
            r_shift       <= '0;
            r_ratio       <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (o_s_tready && i_s_tvalid) begin
                r_mark_phase  <= r_mark_phase + r_mark_step;
                r_space_phase <= r_space_phase + r_space_step;
            end
            if (w_fire) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_fire) begin
                r_known     <= w_new_known;
                r_mark      <= w_new_mark;
                r_ratio     <= w_ratio_new;
                r_bit_clock <= (w_bc >= BIT_LEN) ? 7'd0 : w_bc;
                if (w_slice) begin
                    r_slice_known <= w_new_known;
                    r_slice_mark  <= w_new_mark;
                    r_bits        <= r_bits + 3'd1;
                    r_shift       <= w_byte ? 8'd0 : w_shift_new;
                end
            end
        end
    end

    a_bit_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_clock < BIT_LEN)
        else $error("bit clock out of range");

    a_byte_needs_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[5] |-> o_m_tdata[3])
        else $error("byte completed without a sliced bit");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[20:14] <= 7'd100)
        else $error("signal ratio above 100");

    a_accept_starts_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready && i_s_tvalid |=> r_state == afsk_pkg::ST_MIX && !o_s_tready)
        else $error("accepted word did not start the mixer");

endmodule

`default_nettype wire
